// File: design/lcrcm_pkg.sv
`default_nettype none
package lcrcm_pkg;

  localparam int PALETTE_MAX = 8;
  localparam int NUM_NBR     = 8;
  localparam int CNT_W       = 4;
  localparam int SUM_W       = 11;
  localparam int DIST_W      = 18;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL01   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL23   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL45   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL67   = 3'd6;

  typedef logic [2:0]  pidx_t;
  typedef logic [23:0] rgb_t;
  typedef logic [3:0][47:0] pal_regs_t;
  typedef logic [NUM_NBR-1:0][DIST_W-1:0] dist_vec_t;

  typedef struct packed {
    logic [7:0] centre_cell;
    logic [7:0] north_west;
    logic [7:0] north;
    logic [7:0] north_east;
    logic [7:0] west;
    logic [7:0] east;
    logic [7:0] south_west;
    logic [7:0] south;
    logic [7:0] south_east;
  } in_item_t;

  typedef struct packed {
    logic [7:0] next_cell;
    logic       born;
    logic       died;
  } out_item_t;

  typedef struct packed {
    logic       live;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } nbr_col_t;

  // Two colours per register, the even one in the low half.
  function automatic rgb_t colour_of(pal_regs_t pal, pidx_t idx);
    logic [47:0] word;
    word = pal[idx[2:1]];
    return idx[0] ? word[47:24] : word[23:0];
  endfunction

  // ceil(2^16 / n): exact floor division for sums up to 8 * 255.
  function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/lcrcm_nbr_lane.sv
`default_nettype none
module lcrcm_nbr_lane
  import lcrcm_pkg::*;
(
  input  wire logic [7:0] nbr,
  input  wire pidx_t      last_idx,
  input  wire pal_regs_t  pal,
  output nbr_col_t        col
);

  logic [7:0] ci;
  pidx_t      sel;
  rgb_t       rgb;

  always_comb begin
    ci = nbr - 8'd1;
    // clamp indices past the palette to the last colour in use
    sel = (ci > {5'd0, last_idx}) ? last_idx : ci[2:0];
    rgb = colour_of(pal, sel);
    col.live = (nbr != 8'd0);
    col.r = col.live ? rgb[23:16] : 8'd0;
    col.g = col.live ? rgb[15:8]  : 8'd0;
    col.b = col.live ? rgb[7:0]   : 8'd0;
  end

endmodule
`default_nettype wire

// File: design/lcrcm_dist_lane.sv
`default_nettype none
module lcrcm_dist_lane
  import lcrcm_pkg::*;
(
  input  wire logic [7:0] mean_r,
  input  wire logic [7:0] mean_g,
  input  wire logic [7:0] mean_b,
  input  wire rgb_t       colour,
  output logic [DIST_W-1:0] sq_dist
);

  logic [7:0]  dr, dg, db;
  logic [15:0] sr, sg, sb;

  always_comb begin
    dr = (mean_r >= colour[23:16]) ? mean_r - colour[23:16] : colour[23:16] - mean_r;
    dg = (mean_g >= colour[15:8])  ? mean_g - colour[15:8]  : colour[15:8]  - mean_g;
    db = (mean_b >= colour[7:0])   ? mean_b - colour[7:0]   : colour[7:0]   - mean_b;
    sr = 16'(dr) * 16'(dr);
    sg = 16'(dg) * 16'(dg);
    sb = 16'(db) * 16'(db);
    sq_dist = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  end

endmodule
`default_nettype wire

// File: design/lcrcm_merge.sv
`default_nettype none
module lcrcm_merge
  import lcrcm_pkg::*;
(
  input  wire dist_vec_t lane_dist,
  input  wire pidx_t     last_idx,
  output pidx_t          best
);

  typedef struct packed {
    logic              ok;
    logic [DIST_W-1:0] d;
    pidx_t             idx;
  } cand_t;

  // a holds the lower indices: b wins only when strictly nearer
  function automatic cand_t pick(cand_t a, cand_t b);
    return (b.ok && (!a.ok || (b.d < a.d))) ? b : a;
  endfunction

  cand_t l0 [8];
  cand_t l1 [4];
  cand_t l2 [2];
  cand_t l3;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      l0[i].ok  = (3'(i) <= last_idx);
      l0[i].d   = lane_dist[i];
      l0[i].idx = 3'(i);
    end
    for (int i = 0; i < 4; i++) begin
      l1[i] = pick(l0[2*i], l0[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      l2[i] = pick(l1[2*i], l1[2*i+1]);
    end
    l3 = pick(l2[0], l2[1]);
    best = l3.idx;
  end

endmodule
`default_nettype wire

// File: design/life_cell_rule_colour_mix.sv
`default_nettype none
// Channel  Ports                                   Dir  Payload
// in       in_valid  in_ready  in_data             in   in_item_t (centre, 8 neighbors)
// out      out_valid out_ready out_data            out  out_item_t (next_cell, born, died)
// cfg      cfg_valid cfg_ready cfg_index cfg_data  in   register index, 48-bit value
//
// One request per clock while in_ready is high; an accepted request passes through the
// neighbor lanes and sums, mean by reciprocal multiply, palette distance lanes, then
// the min-distance merge into the output register, which drives out_valid.
// All stages advance together; in_ready drops only while out_valid waits on out_ready.
// rst_n (synchronous) empties the pipe and loads the register reset values.
// cfg_ready is always high.
module life_cell_rule_colour_mix
  import lcrcm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [8:0]       birth_mask_r, survive_mask_r;
  logic [CNT_W-1:0] palette_count_r;
  pal_regs_t        pal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      birth_mask_r    <= 9'd8;
      survive_mask_r  <= 9'd12;
      palette_count_r <= 4'd1;
      pal_r           <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BIRTH:   birth_mask_r    <= cfg_data[8:0];
        CFG_SURVIVE: survive_mask_r  <= cfg_data[8:0];
        CFG_COUNT:   palette_count_r <= cfg_data[CNT_W-1:0];
        CFG_PAL01:   pal_r[0]        <= cfg_data;
        CFG_PAL23:   pal_r[1]        <= cfg_data;
        CFG_PAL45:   pal_r[2]        <= cfg_data;
        CFG_PAL67:   pal_r[3]        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic [CNT_W-1:0] cnt_use;
  pidx_t            last_idx;

  always_comb begin
    if (palette_count_r == '0) begin
      cnt_use = CNT_W'(1);
    end else if (palette_count_r > CNT_W'(PALETTE_MAX)) begin
      cnt_use = CNT_W'(PALETTE_MAX);
    end else begin
      cnt_use = palette_count_r;
    end
    last_idx = 3'(cnt_use - CNT_W'(1));
  end

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Stage 1: neighbor lanes, live count, colour sums, rule lookup
  logic [7:0] nbr [NUM_NBR];
  nbr_col_t   ncol [NUM_NBR];

  assign nbr[0] = in_data.north_west;
  assign nbr[1] = in_data.north;
  assign nbr[2] = in_data.north_east;
  assign nbr[3] = in_data.west;
  assign nbr[4] = in_data.east;
  assign nbr[5] = in_data.south_west;
  assign nbr[6] = in_data.south;
  assign nbr[7] = in_data.south_east;

  for (genvar k = 0; k < NUM_NBR; k++) begin : g_nbr
    lcrcm_nbr_lane u_lane (
      .nbr      (nbr[k]),
      .last_idx (last_idx),
      .pal      (pal_r),
      .col      (ncol[k])
    );
  end

  logic [CNT_W-1:0] n_cnt;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;

  always_comb begin
    n_cnt = '0;
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int k = 0; k < NUM_NBR; k++) begin
      n_cnt = n_cnt + CNT_W'(ncol[k].live);
      sum_r = sum_r + SUM_W'(ncol[k].r);
      sum_g = sum_g + SUM_W'(ncol[k].g);
      sum_b = sum_b + SUM_W'(ncol[k].b);
    end
  end

  logic             s1_v_r, s1_keep_r, s1_birth_r;
  logic [7:0]       s1_centre_r;
  logic [CNT_W-1:0] s1_n_r;
  logic [SUM_W-1:0] s1_sr_r, s1_sg_r, s1_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_centre_r <= in_data.centre_cell;
      s1_n_r      <= n_cnt;
      s1_keep_r   <= survive_mask_r[n_cnt];
      s1_birth_r  <= birth_mask_r[n_cnt];
      s1_sr_r     <= sum_r;
      s1_sg_r     <= sum_g;
      s1_sb_r     <= sum_b;
    end
  end

  // Stage 2: mean colour, floor(sum / n) by reciprocal multiply
  localparam int PROD_W = SUM_W + RECIP_W;
  logic [RECIP_W-1:0] rc;
  logic [PROD_W-1:0]  pr, pg, pb;

  always_comb begin
    rc = recip(s1_n_r);
    pr = PROD_W'(s1_sr_r) * PROD_W'(rc);
    pg = PROD_W'(s1_sg_r) * PROD_W'(rc);
    pb = PROD_W'(s1_sb_r) * PROD_W'(rc);
  end

  logic       s2_v_r, s2_keep_r, s2_birth_r, s2_nzero_r;
  logic [7:0] s2_centre_r, s2_mr_r, s2_mg_r, s2_mb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_centre_r <= s1_centre_r;
      s2_keep_r   <= s1_keep_r;
      s2_birth_r  <= s1_birth_r;
      s2_nzero_r  <= (s1_n_r == '0);
      s2_mr_r     <= pr[RECIP_SHIFT +: 8];
      s2_mg_r     <= pg[RECIP_SHIFT +: 8];
      s2_mb_r     <= pb[RECIP_SHIFT +: 8];
    end
  end

  // Stage 3: one distance lane per palette entry
  dist_vec_t lane_dist;

  for (genvar p = 0; p < PALETTE_MAX; p++) begin : g_dist
    lcrcm_dist_lane u_dist (
      .mean_r  (s2_mr_r),
      .mean_g  (s2_mg_r),
      .mean_b  (s2_mb_r),
      .colour  (colour_of(pal_r, 3'(p))),
      .sq_dist (lane_dist[p])
    );
  end

  logic       s3_v_r, s3_keep_r, s3_birth_r, s3_nzero_r;
  logic [7:0] s3_centre_r;
  dist_vec_t  s3_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_centre_r <= s2_centre_r;
      s3_keep_r   <= s2_keep_r;
      s3_birth_r  <= s2_birth_r;
      s3_nzero_r  <= s2_nzero_r;
      s3_dist_r   <= lane_dist;
    end
  end

  // Stage 4: pick nearest colour and form the result
  pidx_t best;

  lcrcm_merge u_merge (
    .lane_dist (s3_dist_r),
    .last_idx  (last_idx),
    .best      (best)
  );

  out_item_t res;

  always_comb begin
    res = '0;
    if (s3_centre_r != 8'd0) begin
      if (s3_keep_r) begin
        res.next_cell = s3_centre_r;
      end else begin
        res.died = 1'b1;
      end
    end else if (s3_birth_r) begin
      res.born      = 1'b1;
      res.next_cell = s3_nzero_r ? 8'd1 : 8'(best) + 8'd1;
    end
  end

  logic      out_valid_nxt;
  out_item_t out_data_r;

  assign out_valid_nxt = adv ? s3_v_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_born_died_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.born && out_data.died))
    else $error("born and died both set");

  a_born_in_palette: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.born |->
      out_data.next_cell != 8'd0 && out_data.next_cell <= 8'(cnt_use))
    else $error("newborn index outside palette in use");

  a_died_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.died |-> out_data.next_cell == 8'd0)
    else $error("dead cell with nonzero value");

  a_bubble_stays: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> out_valid && $stable(s3_v_r))
    else $error("pipe moved during stall");

endmodule
`default_nettype wire
